@@ src/tlnf_pkg.sv @@
`timescale 1ns / 1ps
package tlnf_pkg;

   localparam int FlagNonblank = 0;
   localparam int FlagDollar   = 1;
   localparam int FlagAll      = 2;
   localparam int FlagSqueeze  = 3;
   localparam int FlagTabs     = 4;
   localparam int FlagsWidth   = 5;

   localparam int QueueDepth   = 2;

   localparam logic [7:0] CHAR_NL       = 8'h0A;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_CARET    = 8'h5E;
   localparam logic [7:0] CHAR_LETTER_I = 8'h49;
   localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;

   localparam logic [3:0] BCD_NINE      = 4'd9;

   typedef struct packed {
      logic       number;
      logic       tab_esc;
      logic       dollar;
      logic [7:0] ch;
   } tlnf_item_type;

   typedef enum logic [3:0] {
      PH_BEGIN,
      PH_PAD,
      PH_DIGIT,
      PH_SP1,
      PH_SP2,
      PH_CARET,
      PH_LETTER_I,
      PH_DOLLAR,
      PH_CHAR
   } tlnf_phase_type;

endpackage

@@ src/tlnf_front.sv @@
`timescale 1ns / 1ps
module tlnf_front #(
   parameter int NUMBER_DIGITS = 7,
   parameter int SIG_W         = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tlnf_pkg::FlagsWidth-1:0]       flags,
   input  logic                                  req_push,
   input  logic [7:0]                            req_in_byte,
   output logic                                  req_full,
   input  logic                                  q_full,
   output logic                                  q_push,
   output tlnf_pkg::tlnf_item_type               q_item,
   output logic [SIG_W-1:0]                      q_sig,
   output logic [NUMBER_DIGITS-1:0][3:0]         q_digits
);
   import tlnf_pkg::*;

   logic [NUMBER_DIGITS-1:0][3:0] line_count_ff, line_count_in, line_inc;
   logic [1:0]                    newline_run_ff, newline_run_in, run_inc;
   logic                          accept, is_nl, drop, number, carry;
   logic [SIG_W-1:0]              sig;

   always_comb begin
      accept  = req_push && !q_full;
      is_nl   = (req_in_byte == CHAR_NL);
      run_inc = (newline_run_ff == 2'd3) ? 2'd3 : newline_run_ff + 2'd1;
      drop    = 1'b0;
      number  = 1'b0;
      newline_run_in = newline_run_ff;
      if (accept) begin
         if (is_nl) begin
            newline_run_in = run_inc;
            drop   = flags[FlagSqueeze] && (run_inc > 2'd2);
            number = !drop && flags[FlagAll] && (run_inc > 2'd1);
         end else begin
            newline_run_in = 2'd0;
            number = (flags[FlagNonblank] || flags[FlagAll]) && (newline_run_ff != 2'd0);
         end
      end

      // count of significant digits, at least one
      sig = SIG_W'(1);
      for (int i = 1; i < NUMBER_DIGITS; i++) begin
         if (line_count_ff[i] != 4'd0) sig = SIG_W'(i + 1);
      end

      // bcd increment, wraps to zero after all nines
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (carry && line_count_ff[i] == BCD_NINE) begin
            line_inc[i] = 4'd0;
         end else if (carry) begin
            line_inc[i] = line_count_ff[i] + 4'd1;
            carry = 1'b0;
         end else begin
            line_inc[i] = line_count_ff[i];
         end
      end

      line_count_in = number ? line_inc : line_count_ff;

      q_push         = accept && !drop;
      q_item.number  = number;
      q_item.tab_esc = (req_in_byte == CHAR_TAB) && flags[FlagTabs];
      q_item.dollar  = is_nl && flags[FlagDollar];
      q_item.ch      = req_in_byte;
      q_sig          = sig;
      q_digits       = line_count_ff;
      req_full       = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff    <= (4 * NUMBER_DIGITS)'(1);
         newline_run_ff   <= 2'd1;
      end else begin
         line_count_ff    <= line_count_in;
         newline_run_ff   <= newline_run_in;
      end
   end

endmodule

@@ src/tlnf_queue.sv @@
`timescale 1ns / 1ps
module tlnf_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              head_valid
);
   import tlnf_pkg::*;

   localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CNT_W = $clog2(QueueDepth + 1);

   logic [DATA_W-1:0] mem_ff [QueueDepth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_ok, pop_ok;

   always_comb begin
      full       = (count_ff == CNT_W'(QueueDepth));
      head_valid = (count_ff != '0);
      head_data  = mem_ff[rd_ptr_ff];
      push_ok    = push && !full;
      pop_ok     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push_ok) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ src/tlnf_back.sv @@
`timescale 1ns / 1ps
module tlnf_back #(
   parameter int NUMBER_DIGITS      = 7,
   parameter int NUMBER_FIELD_WIDTH = 6,
   parameter int SIG_W              = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  tlnf_pkg::tlnf_item_type       head_item,
   input  logic [SIG_W-1:0]              head_sig,
   input  logic [NUMBER_DIGITS-1:0][3:0] head_digits,
   output logic                          head_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run
);
   import tlnf_pkg::*;

   localparam int MAX_W  = (NUMBER_DIGITS > NUMBER_FIELD_WIDTH) ?
                           NUMBER_DIGITS : NUMBER_FIELD_WIDTH;
   localparam int CNT_W  = $clog2(MAX_W + 1);
   localparam int DIDX_W = $clog2(NUMBER_DIGITS);

   tlnf_phase_type phase_ff, phase_in, cur_phase, next_phase, body_first;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cur_cnt, next_cnt, sig_w;
   logic             emit, last;
   logic [7:0]       byte_out;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;

   always_comb begin
      sig_w = CNT_W'(head_sig);
      priority if (head_item.tab_esc) body_first = PH_CARET;
      else if (head_item.dollar)      body_first = PH_DOLLAR;
      else                            body_first = PH_CHAR;

      // a fresh head item picks its first phase here
      cur_phase = phase_ff;
      cur_cnt   = cnt_ff;
      if (phase_ff == PH_BEGIN) begin
         if (!head_item.number) begin
            cur_phase = body_first;
         end else if (sig_w < CNT_W'(NUMBER_FIELD_WIDTH)) begin
            cur_phase = PH_PAD;
            cur_cnt   = sig_w;
         end else begin
            cur_phase = PH_DIGIT;
            cur_cnt   = sig_w - CNT_W'(1);
         end
      end

      byte_out   = CHAR_SPACE;
      next_phase = cur_phase;
      next_cnt   = cur_cnt;
      last       = 1'b0;
      unique case (cur_phase)
         PH_PAD: begin
            byte_out = CHAR_SPACE;
            if (cur_cnt == CNT_W'(NUMBER_FIELD_WIDTH - 1)) begin
               next_phase = PH_DIGIT;
               next_cnt   = sig_w - CNT_W'(1);
            end else begin
               next_cnt   = cur_cnt + CNT_W'(1);
            end
         end
         PH_DIGIT: begin
            byte_out = CHAR_ZERO + {4'd0, head_digits[cur_cnt[DIDX_W-1:0]]};
            if (cur_cnt == '0) next_phase = PH_SP1;
            else               next_cnt   = cur_cnt - CNT_W'(1);
         end
         PH_SP1: begin
            byte_out   = CHAR_SPACE;
            next_phase = PH_SP2;
         end
         PH_SP2: begin
            byte_out   = CHAR_SPACE;
            next_phase = body_first;
         end
         PH_CARET: begin
            byte_out   = CHAR_CARET;
            next_phase = PH_LETTER_I;
         end
         PH_LETTER_I: begin
            byte_out = CHAR_LETTER_I;
            last     = 1'b1;
         end
         PH_DOLLAR: begin
            byte_out   = CHAR_DOLLAR;
            next_phase = PH_CHAR;
         end
         PH_CHAR: begin
            byte_out = head_item.ch;
            last     = 1'b1;
         end
         PH_BEGIN: begin
            byte_out = head_item.ch;
            last     = 1'b1;
         end
      endcase

      emit     = head_valid && (!out_valid_ff || rsp_pop);
      head_pop = emit && last;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (emit) begin
         phase_in = last ? PH_BEGIN : next_phase;
         cnt_in   = next_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BEGIN;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= byte_out;
         out_last_ff <= last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

@@ src/text_line_number_formatter_unit.sv @@
`timescale 1ns / 1ps
// cat-style output formatter: text bytes go in one per transaction and the
// formatted run comes out one byte per transaction, last_of_run marking the
// final byte of each run. With no expansion, bytes flow at one per clock while
// the output is popped; a run's first byte reaches the result ports through the
// queue and the output register after its input is accepted. The back end's
// sequencer emits one output byte per cycle unless its output register is full
// and not popped; a numbered line adds max(NUMBER_FIELD_WIDTH, digits) + 2 bytes
// to the run, "^I" and "$\n" add one. A newline dropped by squeeze gives no
// output and never enters the queue. A two-entry queue between the classifier
// and the sequencer lets input continue while a run is expanding.
// Write format_flags only while the block is idle.
module text_line_number_formatter_unit #(
   parameter int NUMBER_DIGITS      = 7,
   parameter int NUMBER_FIELD_WIDTH = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [7:0]                      req_in_byte,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run,
   input  logic                            csr_write_en,
   input  logic [tlnf_pkg::FlagsWidth-1:0] csr_format_flags
);
   import tlnf_pkg::*;

   localparam int SIG_W  = $clog2(NUMBER_DIGITS + 1);
   localparam int ITEM_W = $bits(tlnf_item_type);
   localparam int DATA_W = ITEM_W + SIG_W + 4 * NUMBER_DIGITS;

   logic [FlagsWidth-1:0]         flags_ff;
   logic                          q_full, q_push, q_pop, q_valid;
   tlnf_item_type                 f_item, h_item;
   logic [SIG_W-1:0]              f_sig, h_sig;
   logic [NUMBER_DIGITS-1:0][3:0] f_digits, h_digits;
   logic [DATA_W-1:0]             q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (csr_write_en) begin
         flags_ff <= csr_format_flags;
      end
   end

   tlnf_front #(
      .NUMBER_DIGITS(NUMBER_DIGITS),
      .SIG_W        (SIG_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .flags      (flags_ff),
      .req_push   (req_push),
      .req_in_byte(req_in_byte),
      .req_full   (req_full),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (f_item),
      .q_sig      (f_sig),
      .q_digits   (f_digits)
   );

   assign q_wdata = {f_item, f_sig, f_digits};
   assign {h_item, h_sig, h_digits} = q_rdata;

   tlnf_queue #(
      .DATA_W(DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_rdata),
      .head_valid(q_valid)
   );

   tlnf_back #(
      .NUMBER_DIGITS     (NUMBER_DIGITS),
      .NUMBER_FIELD_WIDTH(NUMBER_FIELD_WIDTH),
      .SIG_W             (SIG_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_valid),
      .head_item      (h_item),
      .head_sig       (h_sig),
      .head_digits    (h_digits),
      .head_pop       (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // a run never breaks up: the next byte follows the popped one at once
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_of_run) |=> !rsp_empty)
      else $error("output run broke before its last byte");

   // nothing appears at the output without a queued item
   assert property (@(posedge clock) disable iff (reset)
      (!q_valid && rsp_empty) |=> rsp_empty)
      else $error("output byte with no queued item");

   // a finished run with nothing queued leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !q_valid) |=> rsp_empty)
      else $error("output stayed valid with nothing to send");

   // the sequencer only pops the queue on a final byte
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (!rsp_empty && rsp_last_of_run))
      else $error("queue popped without a final byte");

endmodule

@@ dv/tlnf_stream_checker.sv @@
`timescale 1ns / 1ps
module tlnf_stream_checker #(
   parameter int NUMBER_DIGITS      = 7,
   parameter int NUMBER_FIELD_WIDTH = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic                            req_full,
   input  logic [7:0]                      req_in_byte,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  logic [7:0]                      rsp_out_byte,
   input  logic                            rsp_last_of_run,
   input  logic                            csr_write_en,
   input  logic [tlnf_pkg::FlagsWidth-1:0] csr_format_flags,
   output int                              error_count,
   output int                              pending_count,
   output int                              result_count,
   output int                              numbered_count
);
   import tlnf_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   out_char_type               expected_chars[$];
   logic [FlagsWidth-1:0]      flags;
   logic [4*NUMBER_DIGITS-1:0] line_bcd;
   logic [1:0]                 nl_run;
   int                         errors;
   int                         results;
   int                         numbered;

   task automatic bump_line_count();
      logic [4:0] d;
      logic       carry;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         d = {1'b0, line_bcd[4*i +: 4]} + 5'(carry);
         if (d > 5'd9) begin
            d = '0;
            carry = 1'b1;
         end else begin
            carry = 1'b0;
         end
         line_bcd[4*i +: 4] = d[3:0];
      end
   endtask

   // expected output run for one accepted text byte
   task automatic format_char(input logic [7:0] c);
      logic       number;
      logic       found;
      int         sig;
      logic [7:0] run_chars[$];
      if (c == CHAR_NL) begin
         if (nl_run < 2'd3)
            nl_run = nl_run + 2'd1;
         // squeezed blank line: nothing comes out
         if (flags[FlagSqueeze] && nl_run > 2'd2)
            return;
         number = flags[FlagAll] && nl_run > 2'd1;
      end else begin
         number = (flags[FlagNonblank] || flags[FlagAll]) && nl_run != 2'd0;
         nl_run = 2'd0;
      end

      if (number) begin
         sig = 1;
         found = 1'b0;
         for (int i = NUMBER_DIGITS - 1; i > 0; i--) begin
            if (!found && line_bcd[4*i +: 4] != 4'd0) begin
               sig = i + 1;
               found = 1'b1;
            end
         end
         for (int i = sig; i < NUMBER_FIELD_WIDTH; i++)
            run_chars.push_back(CHAR_SPACE);
         for (int i = sig - 1; i >= 0; i--)
            run_chars.push_back(8'(CHAR_ZERO + 8'(line_bcd[4*i +: 4])));
         run_chars.push_back(CHAR_SPACE);
         run_chars.push_back(CHAR_SPACE);
         bump_line_count();
         numbered++;
      end

      if (c == CHAR_TAB && flags[FlagTabs]) begin
         run_chars.push_back(CHAR_CARET);
         run_chars.push_back(CHAR_LETTER_I);
      end else begin
         if (c == CHAR_NL && flags[FlagDollar])
            run_chars.push_back(CHAR_DOLLAR);
         run_chars.push_back(c);
      end

      foreach (run_chars[i])
         expected_chars.push_back('{ch: run_chars[i], last: (i == run_chars.size() - 1)});
   endtask

   task automatic check_char();
      out_char_type want;
      results++;
      if (expected_chars.size() == 0) begin
         errors++;
         $display("%0t: output byte %h last %b with nothing expected", $time,
                  rsp_out_byte, rsp_last_of_run);
      end else begin
         want = expected_chars.pop_front();
         if (rsp_out_byte !== want.ch) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.ch, rsp_out_byte);
         end
         if (rsp_last_of_run !== want.last) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                     rsp_last_of_run);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         flags = '0;
         line_bcd = (4 * NUMBER_DIGITS)'(1);
         nl_run = 2'd1;
         expected_chars.delete();
         errors = 0;
         results = 0;
         numbered = 0;
      end else begin
         if (csr_write_en)
            flags = csr_format_flags;
         // predict before checking so a same-edge transaction is covered
         if (req_push && !req_full)
            format_char(req_in_byte);
         if (rsp_pop && !rsp_empty)
            check_char();
      end
      error_count    <= errors;
      pending_count  <= expected_chars.size();
      result_count   <= results;
      numbered_count <= numbered;
   end

endmodule

@@ dv/text_line_number_formatter_unit_tb.sv @@
`timescale 1ns / 1ps
module text_line_number_formatter_unit_tb;
   import tlnf_pkg::*;

   localparam int NUMBER_DIGITS      = 7;
   localparam int NUMBER_FIELD_WIDTH = 6;
   localparam int DRAIN_CYCLES       = 24;
   localparam int RANDOM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE    = 31;

   localparam logic [FlagsWidth-1:0] F_NONBLANK = FlagsWidth'(1 << FlagNonblank);
   localparam logic [FlagsWidth-1:0] F_DOLLAR   = FlagsWidth'(1 << FlagDollar);
   localparam logic [FlagsWidth-1:0] F_ALL      = FlagsWidth'(1 << FlagAll);
   localparam logic [FlagsWidth-1:0] F_SQUEEZE  = FlagsWidth'(1 << FlagSqueeze);
   localparam logic [FlagsWidth-1:0] F_TABS     = FlagsWidth'(1 << FlagTabs);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic [7:0]            req_in_byte = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last_of_run;
   logic                  csr_write_en = 1'b0;
   logic [FlagsWidth-1:0] csr_format_flags = '0;

   int error_count;
   int pending_count;
   int result_count;
   int numbered_count;

   bit idle_on = 1'b0;
   int bytes_sent = 0;
   int settings_used = 0;
   int pop_stall = 0;

   always #5 clock = ~clock;

   text_line_number_formatter_unit #(
      .NUMBER_DIGITS     (NUMBER_DIGITS),
      .NUMBER_FIELD_WIDTH(NUMBER_FIELD_WIDTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_in_byte     (req_in_byte),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_en    (csr_write_en),
      .csr_format_flags(csr_format_flags)
   );

   tlnf_stream_checker #(
      .NUMBER_DIGITS     (NUMBER_DIGITS),
      .NUMBER_FIELD_WIDTH(NUMBER_FIELD_WIDTH)
   ) stream_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_en    (csr_write_en),
      .csr_format_flags(csr_format_flags),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .numbered_count  (numbered_count)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // text-like mix: lots of newlines and tabs, some arbitrary bytes
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return CHAR_NL;
      if (r < 42)
         return CHAR_TAB;
      if (r < 85)
         return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall--;
      end else begin
         rsp_pop <= 1'b1;
         pop_stall = pick_gap();
      end
   end

   task automatic send_char(input logic [7:0] c);
      int gap;
      @(negedge clock);
      req_push <= 1'b1;
      req_in_byte <= c;
      forever begin
         @(posedge clock);
         if (!req_full)
            break;
      end
      bytes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // wait until every predicted byte is out, then let a dropped newline clear
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_flags(input logic [FlagsWidth-1:0] value);
      settle();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_format_flags <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [FlagsWidth-1:0] phase_flags[RANDOM_PHASES];
      logic [7:0]            c;
      phase_flags = '{'0, '1, F_NONBLANK, F_DOLLAR, F_ALL, F_SQUEEZE, F_TABS,
                      F_NONBLANK | F_SQUEEZE, F_ALL | F_SQUEEZE | F_DOLLAR, '0};
      phase_flags[RANDOM_PHASES - 1] = FlagsWidth'($urandom_range(0, 31));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // everything on: numbering, squeeze, dollar, tab escape, extreme bytes
      idle_on = 1'b1;
      write_flags('1);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHAR_TAB);
      send_char(CHAR_NL);
      send_char(CHAR_NL);
      send_char(CHAR_NL);
      send_char(CHAR_NL);
      send_char(8'h78);
      send_char(CHAR_TAB);
      send_char(CHAR_NL);
      send_char(8'h80);
      send_char(8'h7F);

      // nonblank numbering with squeeze, tabs passed through
      write_flags(F_NONBLANK | F_SQUEEZE);
      send_char(CHAR_NL);
      send_char(CHAR_NL);
      send_char(CHAR_NL);
      send_char(8'h61);
      send_char(CHAR_NL);
      send_char(CHAR_NL);
      send_char(CHAR_TAB);
      send_char(CHAR_NL);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_flags(phase_flags[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 12 == 0)
               idle_on = ($urandom_range(0, 3) != 0);
            c = pick_char();
            // sometimes a run of blank lines to exercise squeeze and the run counter
            if (c == CHAR_NL && $urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) send_char(CHAR_NL);
            end
            send_char(c);
         end
      end

      settle();
      $display("checked %0d output bytes from %0d text bytes over %0d flag settings",
               result_count, bytes_sent, settings_used);
      $display("%0d line numbers predicted and compared", numbered_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
